@@ src/colorkey_sprite_store_emitter_macros.svh @@
// Assertion macros used by the sprite store emitter RTL top level.
// Uses clk and rst_n from the scope of the module that includes it.
`ifndef COLORKEY_SPRITE_STORE_EMITTER_MACROS_SVH
`define COLORKEY_SPRITE_STORE_EMITTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// pre holds -> post holds in the same cycle
`define CSSE_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("csse: same-cycle check failed");

// pre holds -> post holds in the next cycle
`define CSSE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("csse: next-cycle check failed");

`else

`define CSSE_ASSERT_IMPLY(label, pre, post)
`define CSSE_ASSERT_NEXT(label, pre, post)

`endif

`endif

@@ src/csse_pkg.sv @@
// Shared types, constants and register map of the color-key sprite store emitter.
// No dependencies; every other file but the macros header imports this package.
package csse_pkg;

    localparam int PIXEL_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int OFFSET_W = 12;
    localparam int KEY_W    = 8;
    localparam int PITCH_W  = 16;
    localparam int SWIDTH_W = 13;
    localparam int BUF_W    = 24;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    // APB register map
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_COLOR_KEY    = 2'd0;
    localparam logic [1:0] REG_FB_PITCH     = 2'd1;
    localparam logic [1:0] REG_SPRITE_WIDTH = 2'd2;

    localparam logic [KEY_W-1:0]    COLOR_KEY_RST    = 8'd0;
    localparam logic [PITCH_W-1:0]  FB_PITCH_RST     = 16'd320;
    localparam logic [SWIDTH_W-1:0] SPRITE_WIDTH_RST = 13'd16;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_HALF = 2'd2,
        KIND_WORD = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] offset;
    } cmd_t;

    // One queue entry: all commands caused by one pixel (one or two)
    typedef struct packed {
        logic two;
        cmd_t first;
        cmd_t second;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [KEY_W-1:0]    color_key;
        logic [PITCH_W-1:0]  fb_pitch;
        logic [SWIDTH_W-1:0] sprite_width;
    } cfg_t;

    typedef enum logic {
        SEL_FIRST,
        SEL_SECOND
    } sel_t;

endpackage

@@ src/csse_ifs.sv @@
// Stream interfaces of the sprite store emitter: pixel input and command output.
// Depends on csse_pkg for field widths.
interface csse_pix_if
    import csse_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               sprite_end;

    modport source (output valid, pixel, sprite_end, input ready);
    modport sink   (input valid, pixel, sprite_end, output ready);
endinterface

interface csse_cmd_if
    import csse_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] offset;
    logic                last;

    modport source (output valid, kind, value, offset, last, input ready);
    modport sink   (input valid, kind, value, offset, last, output ready);
endinterface

@@ src/csse_cfg.sv @@
// APB configuration registers: color key, framebuffer pitch, sprite width.
// Depends on csse_pkg for the register map and reset values.
module csse_cfg
    import csse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_key    <= COLOR_KEY_RST;
            cfg_reg.fb_pitch     <= FB_PITCH_RST;
            cfg_reg.sprite_width <= SPRITE_WIDTH_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_COLOR_KEY:    cfg_reg.color_key    <= pwdata[KEY_W-1:0];
                REG_FB_PITCH:     cfg_reg.fb_pitch     <= pwdata[PITCH_W-1:0];
                REG_SPRITE_WIDTH: cfg_reg.sprite_width <= pwdata[SWIDTH_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_COLOR_KEY:    prdata = APB_DW'(cfg_reg.color_key);
            REG_FB_PITCH:     prdata = APB_DW'(cfg_reg.fb_pitch);
            REG_SPRITE_WIDTH: prdata = APB_DW'(cfg_reg.sprite_width);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ src/csse_front.sv @@
// Front end: accepts pixels, tracks runs and the pending add, builds command records.
// Depends on csse_pkg and csse_pix_if.
module csse_front
    import csse_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    csse_pix_if.sink pix,
    input  q_stat_t q_stat,
    output logic    push,
    output rec_t    push_rec
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RLW = WW;
    localparam logic signed [33:0] SAT_HI = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_LO = -34'sh0_8000_0000;

    logic signed [VALUE_W-1:0] pend_reg, pend_next;
    logic [CW-1:0]             col_reg, col_next;
    logic [RLW-1:0]            rl_reg, rl_next;
    logic [BUF_W-1:0]          buf_reg, buf_next;
    logic                      run_reg, run_next;
    logic                      past_reg, past_next;

    logic                      accept, opaque, row_start, row_end, flush;
    logic                      add_hit, word_hit;
    logic [WW-1:0]             w_eff;
    logic signed [33:0]        pend34, dd, dd1, sum1, sum2;
    logic [VALUE_W-1:0]        sat1, inc_val;
    logic [RLW-1:0]            rl_base, rl_new;
    logic [BUF_W-1:0]          buf_base, buf_new;
    logic [1:0]                idx, rem, fcount;
    logic [OFFSET_W-1:0]       off_new, off_base;
    cmd_t                      add_cmd, word_cmd, f0, f1;

    assign pix.ready = !q_stat.full;
    assign accept    = pix.valid && pix.ready;
    assign opaque    = pix.pixel != cfg.color_key;

    // effective width: zero acts as one, clamp at MAX_WIDTH
    always_comb
    begin
        if (cfg.sprite_width == '0)
            w_eff = WW'(1);
        else if (32'(cfg.sprite_width) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg.sprite_width);
    end

    assign row_start = (col_reg == '0) && past_reg;
    assign row_end   = (32'(col_reg) + 32'd1 >= 32'(w_eff)) || pix.sprite_end;

    // row delta and the two saturating sums, computed side by side
    assign pend34 = 34'(pend_reg);
    assign dd     = row_start ? ($signed(34'(cfg.fb_pitch)) - $signed(34'(w_eff))) : '0;
    assign dd1    = dd + 34'sd1;
    assign sum1   = pend34 + dd;
    assign sum2   = pend34 + dd1;

    always_comb
    begin
        if (sum1 > SAT_HI)
            sat1 = 32'h7FFF_FFFF;
        else if (sum1 < SAT_LO)
            sat1 = 32'h8000_0000;
        else
            sat1 = sum1[VALUE_W-1:0];

        // transparent pixel: saturate after the row delta, then again after +1
        if (sum1 < SAT_LO)
            inc_val = 32'h8000_0001;
        else if (sum2 > SAT_HI)
            inc_val = 32'h7FFF_FFFF;
        else
            inc_val = sum2[VALUE_W-1:0];
    end

    assign rl_base  = run_reg ? rl_reg : '0;
    assign buf_base = run_reg ? buf_reg : '0;
    assign idx      = rl_base[1:0];
    assign word_hit = opaque && run_reg && (idx == 2'd3);
    assign add_hit  = opaque && !run_reg && (sat1 != '0);
    assign rl_new   = opaque ? rl_base + RLW'(1) : rl_reg;

    always_comb
    begin
        if (!opaque)
            buf_new = buf_reg;
        else if (word_hit)
            buf_new = '0;
        else
            buf_new = buf_base | (BUF_W'(pix.pixel) << {idx, 3'b000});
    end

    assign flush    = (!opaque && run_reg) || (opaque && row_end);
    assign rem      = rl_new[1:0];
    assign off_new  = OFFSET_W'(rl_new);
    assign off_base = OFFSET_W'(rl_base);

    assign add_cmd  = '{kind: KIND_ADD, value: sat1, offset: '0};
    assign word_cmd = '{kind: KIND_WORD, value: {pix.pixel, buf_base},
                        offset: {off_base[OFFSET_W-1:2], 2'b00}};

    // remainder of a closing run
    always_comb
    begin
        f0     = '{kind: KIND_BYTE, value: {24'd0, buf_new[7:0]},
                   offset: {off_new[OFFSET_W-1:2], 2'b00}};
        f1     = '{kind: KIND_HALF, value: {16'd0, buf_new[23:8]},
                   offset: {off_new[OFFSET_W-1:2], 2'b01}};
        fcount = 2'd0;
        case (rem)
            2'd3:
            begin
                fcount = 2'd2;
            end
            2'd2:
            begin
                f0.kind  = KIND_HALF;
                f0.value = {16'd0, buf_new[15:0]};
                fcount   = 2'd1;
            end
            2'd1:
            begin
                fcount = 2'd1;
            end
            default:
            begin
                fcount = 2'd0;
            end
        endcase
        if (!flush)
            fcount = 2'd0;
    end

    always_comb
    begin
        logic [1:0] total;
        total = 2'(add_hit) + 2'(word_hit) + fcount;
        push_rec.first  = add_hit ? add_cmd : (word_hit ? word_cmd : f0);
        push_rec.second = add_hit ? f0 : f1;
        push_rec.two    = total == 2'd2;
        push            = accept && (total != 2'd0);
    end

    always_comb
    begin
        pend_next = pend_reg;
        rl_next   = rl_reg;
        buf_next  = buf_reg;
        run_next  = run_reg;
        col_next  = col_reg;
        past_next = past_reg;
        if (accept)
        begin
            if (flush)
                pend_next = VALUE_W'(rl_new) + VALUE_W'(!opaque);
            else if (opaque)
                pend_next = run_reg ? pend_reg : '0;
            else
                pend_next = inc_val;
            rl_next   = flush ? '0 : rl_new;
            buf_next  = flush ? '0 : buf_new;
            run_next  = opaque && !flush;
            col_next  = row_end ? '0 : CW'(32'(col_reg) + 32'd1);
            past_next = past_reg || row_end;
            if (pix.sprite_end)
            begin
                pend_next = '0;
                rl_next   = '0;
                buf_next  = '0;
                run_next  = 1'b0;
                col_next  = '0;
                past_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            rl_reg   <= '0;
            buf_reg  <= '0;
            run_reg  <= 1'b0;
            col_reg  <= '0;
            past_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            rl_reg   <= rl_next;
            buf_reg  <= buf_next;
            run_reg  <= run_next;
            col_reg  <= col_next;
            past_reg <= past_next;
        end
    end

endmodule

@@ src/csse_queue.sv @@
// Short record queue between the front end and the command emitter.
// Depends on csse_pkg for rec_t and q_stat_t.
module csse_queue
    import csse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  rec_t    push_rec,
    input  logic    pop,
    output rec_t    head,
    output q_stat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    rec_t          slots [DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    assign stat.full  = cnt_reg == NW'(DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign head       = slots[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + NW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_reg] <= push_rec;
    end

endmodule

@@ src/csse_back.sv @@
// Back end: unpacks queued records into single commands behind an output register.
// Depends on csse_pkg and csse_cmd_if.
module csse_back
    import csse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  rec_t    head,
    input  q_stat_t q_stat,
    output logic    pop,
    csse_cmd_if.source cmd
);

    sel_t sel_reg, sel_next;
    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic last_reg, last_next;
    logic load, is_last;

    assign cmd.valid  = valid_reg;
    assign cmd.kind   = cmd_reg.kind;
    assign cmd.value  = cmd_reg.value;
    assign cmd.offset = cmd_reg.offset;
    assign cmd.last   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= SEL_FIRST;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // refill the output register whenever a record waits and the register is empty or being taken
    always_comb
    begin
        load       = !q_stat.empty && (!valid_reg || cmd.ready);
        sel_next   = sel_reg;
        cmd_next   = cmd_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !cmd.ready;
        is_last    = 1'b1;
        case (sel_reg)
            SEL_FIRST:
            begin
                is_last = !head.two;
                if (load)
                begin
                    cmd_next = head.first;
                    sel_next = is_last ? SEL_FIRST : SEL_SECOND;
                end
            end
            SEL_SECOND:
            begin
                is_last = 1'b1;
                if (load)
                begin
                    cmd_next = head.second;
                    sel_next = SEL_FIRST;
                end
            end
            default:
            begin
                sel_next = SEL_FIRST;
            end
        endcase
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = is_last;
        end
        pop = load && is_last;
    end

endmodule

@@ src/colorkey_sprite_store_emitter.sv @@
// Top level of the color-key sprite store emitter: config port, front end, queue, back end.
// Depends on csse_pkg, csse_ifs, csse_cfg, csse_front, csse_queue, csse_back and the macros.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------
//  pix     | in  | valid/ready          | pixel[7:0], sprite_end
//  cmd     | out | valid/ready          | kind[1:0], value[31:0], offset[11:0], last
//  APB     | in  | psel/penable/pready  | paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One pixel is taken per cycle while the record queue has room; the front end
// does all per-pixel work (key compare, run counters, saturating add) in that cycle.
// Each pixel yields zero, one or two commands; the back end sends one command per cycle
// while cmd.ready is high, and the queue absorbs bursts of two-command pixels.
// Reset clears the run state and loads the register defaults; nothing needs clearing after.
// A stalled cmd side fills the queue (QUEUE_DEPTH records), then pix.ready drops.
`include "colorkey_sprite_store_emitter_macros.svh"

module colorkey_sprite_store_emitter
    import csse_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    csse_pix_if.sink          pix,
    csse_cmd_if.source        cmd
);

    cfg_t    cfg;
    q_stat_t q_stat;
    logic    front_push;
    rec_t    front_rec;
    logic    back_pop;
    rec_t    q_head;

    // configuration registers, to be written only while the block is idle; the block does not enforce this
    csse_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // classify pixels and build one record of commands per pixel that yields any
    csse_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pix      (pix),
        .q_stat   (q_stat),
        .push     (front_push),
        .push_rec (front_rec)
    );

    // hold records so the two sides stall independently
    csse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_rec (front_rec),
        .pop      (back_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // drain records one command at a time
    csse_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .pop    (back_pop),
        .cmd    (cmd)
    );

    // never push into a full queue
    `CSSE_ASSERT_IMPLY(a_no_overflow, q_stat.full, !front_push)
    // the second command of a pixel follows right behind the first
    `CSSE_ASSERT_NEXT(a_second_ready, cmd.valid && cmd.ready && !cmd.last, cmd.valid)
    // an add carries a nonzero amount and no offset
    `CSSE_ASSERT_IMPLY(a_add_shape, cmd.valid && cmd.kind == KIND_ADD, cmd.offset == '0 && cmd.value != '0)

endmodule

@@ tb/colorkey_sprite_store_emitter_tb.sv @@
// Self-checking testbench of the color-key sprite store emitter: pixel stream in, command stream out.
// Depends on csse_pkg, the csse_pix_if / csse_cmd_if interfaces and the colorkey_sprite_store_emitter RTL.
// A scoreboard class predicts the commands of every accepted pixel; tasks drive APB and the pixel item.
module colorkey_sprite_store_emitter_tb
    import csse_pkg::*;
();

    localparam int CLK_HALF  = 5;
    localparam int LIMIT     = 2_000_000;
    localparam int SETTLE    = 16;
    localparam int LONG_HOLD = 120;

    // One command still owed by the block, with its end-of-pixel flag
    typedef struct {
        cmd_t cmd;
        logic last;
    } due_cmd_t;

    // Predicts the add/store commands of each pixel and checks the block's commands against them
    class store_cmd_scoreboard;
        logic [KEY_W-1:0]    key;
        logic [PITCH_W-1:0]  pitch;
        logic [SWIDTH_W-1:0] swidth;

        longint              dest_add;
        int                  col;
        int                  run_len;
        logic [BUF_W-1:0]    run_bytes;
        bit                  run_open;
        bit                  past_row0;

        due_cmd_t            due[$];
        int                  produced;
        int                  errors;
        int                  pixels;
        int                  checked;
        int                  kind_seen[4];

        function new();
            key    = COLOR_KEY_RST;
            pitch  = FB_PITCH_RST;
            swidth = SPRITE_WIDTH_RST;
            clear_run_state();
            errors  = 0;
            pixels  = 0;
            checked = 0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
        endfunction

        function void clear_run_state();
            dest_add  = 0;
            col       = 0;
            run_len   = 0;
            run_bytes = '0;
            run_open  = 0;
            past_row0 = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_COLOR_KEY:    key    = val[KEY_W-1:0];
                REG_FB_PITCH:     pitch  = val[PITCH_W-1:0];
                REG_SPRITE_WIDTH: swidth = val[SWIDTH_W-1:0];
                default: ;
            endcase
        endfunction

        function int row_width();
            int w;
            w = swidth;
            if (w == 0)
                w = 1;
            if (w > MAX_WIDTH_DEF)
                w = MAX_WIDTH_DEF;
            return w;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function void add_cmd(kind_t k, logic [31:0] v, int off);
            due_cmd_t d;
            d.cmd.kind   = k;
            d.cmd.value  = v;
            d.cmd.offset = off[OFFSET_W-1:0];
            d.last       = 1'b0;
            due.push_back(d);
            produced++;
        endfunction

        // Emit the tail of a run (byte+half, half, or byte) and carry its length forward
        function void close_run();
            int rem;
            int base;
            rem  = run_len % 4;
            base = run_len - rem;
            if (rem == 3) begin
                add_cmd(KIND_BYTE, {24'd0, run_bytes[7:0]}, base);
                add_cmd(KIND_HALF, {16'd0, run_bytes[23:8]}, base + 1);
            end
            else if (rem == 2)
                add_cmd(KIND_HALF, {16'd0, run_bytes[15:0]}, base);
            else if (rem == 1)
                add_cmd(KIND_BYTE, {24'd0, run_bytes[7:0]}, base);
            dest_add  = run_len;
            run_len   = 0;
            run_bytes = '0;
            run_open  = 0;
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] px, logic fin);
            int       w;
            due_cmd_t tail;
            pixels++;
            produced = 0;
            w = row_width();

            // new row after the first: step over the rest of the scanline
            if (col == 0 && past_row0)
                dest_add = clamp32(dest_add + longint'(pitch) - w);

            if (px != key) begin
                if (!run_open) begin
                    if (dest_add != 0)
                        add_cmd(KIND_ADD, dest_add[31:0], 0);
                    dest_add  = 0;
                    run_open  = 1;
                    run_len   = 0;
                    run_bytes = '0;
                end
                if (run_len % 4 == 3) begin
                    add_cmd(KIND_WORD, {px, run_bytes}, run_len - 3);
                    run_bytes = '0;
                end
                else
                    run_bytes[8*(run_len % 4) +: 8] = px;
                run_len++;
            end
            else begin
                if (run_open)
                    close_run();
                dest_add = clamp32(dest_add + 1);
            end

            if (col + 1 >= w || fin) begin
                if (run_open)
                    close_run();
                col       = 0;
                past_row0 = 1;
            end
            else
                col++;

            if (fin)
                clear_run_state();

            if (produced > 0) begin
                tail = due.pop_back();
                tail.last = 1'b1;
                due.push_back(tail);
            end
        endfunction

        function void check_cmd(logic [1:0] k, logic [31:0] v, logic [11:0] off, logic lst);
            due_cmd_t d;
            if (due.size() == 0) begin
                $error("command with none outstanding: kind %0d value %h offset %0d last %0d",
                       k, v, off, lst);
                errors++;
                return;
            end
            d = due.pop_front();
            checked++;
            if (!$isunknown(k))
                kind_seen[k]++;
            if (d.cmd.kind !== k) begin
                $error("kind: expected %0d, got %0d", d.cmd.kind, k);
                errors++;
            end
            if (d.cmd.value !== v) begin
                $error("value: expected %h, got %h", d.cmd.value, v);
                errors++;
            end
            if (d.cmd.offset !== off) begin
                $error("offset: expected %0d, got %0d", d.cmd.offset, off);
                errors++;
            end
            if (d.last !== lst) begin
                $error("last: expected %0d, got %0d", d.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    csse_pix_if pix_if ();
    csse_cmd_if cmd_if ();

    colorkey_sprite_store_emitter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix_if),
        .cmd     (cmd_if)
    );

    store_cmd_scoreboard sb;

    bit calm;           // when set, neither side inserts gaps
    bit long_hold_req;  // main asks the command sink for one long hold-off
    int apb_faults;
    int settings;
    int random_items;
    int cycles;

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Gap length for either side: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Opaque pixels take any value but the key, so every pixel bit toggles
    function automatic logic [PIXEL_W-1:0] pick_pixel(int opaque_pct);
        logic [PIXEL_W-1:0] px;
        if ($urandom_range(0, 99) < opaque_pct) begin
            px = PIXEL_W'($urandom_range(0, 255));
            if (px == sb.key)
                px = ~px;
        end
        else
            px = sb.key;
        return px;
    endfunction

    function automatic logic [PITCH_W-1:0] rand_pitch();
        case ($urandom_range(0, 2))
            0:       return PITCH_W'($urandom_range(1, 40));
            1:       return PITCH_W'($urandom_range(1, 400));
            default: return PITCH_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // Offer one pixel item; hold it until the block takes it, then log it for prediction.
    // Enter and leave at a falling edge.
    task automatic send_pixel(logic [PIXEL_W-1:0] px, logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.pixel      <= px;
        pix_if.sprite_end <= fin;
        do
            @(posedge clk);
        while (pix_if.ready !== 1'b1);
        sb.note_pixel(px, fin);
        @(negedge clk);
    endtask

    task automatic send_sprite(int npix, int opaque_pct);
        for (int i = 0; i < npix; i++)
            send_pixel(pick_pixel(opaque_pct), i == npix - 1);
    endtask

    // Well-formed sprites of one to four rows, some cut short by an early end
    task automatic random_sprites(int budget);
        int sent;
        int n;
        int pct;
        sent = 0;
        while (sent < budget) begin
            n = $urandom_range(1, 4) * sb.row_width();
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, n);
            case ($urandom_range(0, 3))
                0:       pct = 25;
                1:       pct = 60;
                2:       pct = 85;
                default: pct = 100;
            endcase
            send_sprite(n, pct);
            sent += n;
        end
        random_items += sent;
    endtask

    // Stop offering pixels, wait for every owed command, then let in-flight pixels settle
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (sb.due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write one register, then read it back within the same select
    task automatic set_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.set_reg(idx, val);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== val) begin
            $error("readback of register %0d: expected %h, got %h", idx, val, prdata);
            apb_faults++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(logic [KEY_W-1:0] k, logic [PITCH_W-1:0] p,
                             logic [SWIDTH_W-1:0] w);
        drain();
        set_reg(REG_COLOR_KEY, 32'(k));
        set_reg(REG_FB_PITCH, 32'(p));
        set_reg(REG_SPRITE_WIDTH, 32'(w));
        settings++;
    endtask

    // Hand-built sprite under the reset registers (key 0, pitch 320, width 16):
    // word store, three/two/one byte tails, adds before each run, a row step,
    // an early sprite end that flushes a half-word, and a one-pixel sprite.
    task automatic directed_pixels();
        logic [8:0] seq [0:18] = '{
            9'h000, 9'h0FF, 9'h001, 9'h080, 9'h07F, 9'h0AA, 9'h055, 9'h033,
            9'h000, 9'h011, 9'h022, 9'h000, 9'h044, 9'h000, 9'h000, 9'h0EE,
            9'h099, 9'h112, 9'h1FF
        };
        foreach (seq[i])
            send_pixel(seq[i][7:0], seq[i][8]);
    endtask

    // Command sink: random ready, plus one long hold-off counted here on request
    initial
    begin
        int hold;
        cmd_if.ready = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                cmd_if.ready <= 1'b0;
                hold--;
            end
            else begin
                cmd_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    // Check every command item taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
            sb.check_cmd(cmd_if.kind, cmd_if.value, cmd_if.offset, cmd_if.last);
    end

    // Watchdog: end the run once it reaches the cycle limit
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $error("cycle limit of %0d reached", LIMIT);
        $display("colorkey_sprite_store_emitter verification failed");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pix_if.valid      = 1'b0;
        pix_if.pixel      = '0;
        pix_if.sprite_end = 1'b0;
        calm              = 1'b0;
        long_hold_req     = 1'b0;
        apb_faults        = 0;
        settings          = 1;
        random_items      = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values of the registers, no writes yet
        directed_pixels();

        // Narrow pitch: the row step goes negative; key at the top of its range
        configure(8'hFF, 16'd1, 13'd7);
        random_sprites(120);

        // Widest pitch with one-pixel rows
        configure(KEY_W'($urandom_range(0, 255)), 16'hFFFF, 13'd1);
        random_sprites(80);

        // Width 0 behaves as width 1
        configure(KEY_W'($urandom_range(0, 255)), 16'd3, 13'd0);
        random_sprites(60);

        // Lower the width mid-row: the next pixel closes the row
        configure(KEY_W'($urandom_range(0, 255)), 16'd200, 13'd32);
        for (int i = 0; i < 20; i++)
            send_pixel(pick_pixel(70), 1'b0);
        configure(sb.key, sb.pitch, 13'd8);
        send_sprite(30, 70);

        // Hold off the command side while pixels keep coming: fill the queue,
        // stall the input, then pause the sender until everything drains
        configure(KEY_W'($urandom_range(0, 255)), rand_pitch(), 13'd12);
        long_hold_req = 1'b1;
        random_sprites(150);
        drain();

        // Random settings, some phases without any gaps
        repeat (6) begin
            calm = ($urandom_range(0, 3) == 0);
            configure(KEY_W'($urandom_range(0, 255)), rand_pitch(),
                      SWIDTH_W'($urandom_range(1, 24)));
            random_sprites(80);
        end
        calm = 1'b0;

        // Width above the maximum: a short sprite that ends early on the long row
        configure(8'h5A, 16'd4100, 13'h1FFF);
        send_sprite(40, 60);

        drain();

        $display("summary: %0d pixels (%0d in random sprites), %0d commands, %0d register settings",
                 sb.pixels, random_items, sb.checked, settings);
        $display("summary: adds %0d, byte stores %0d, half-word stores %0d, word stores %0d",
                 sb.kind_seen[KIND_ADD], sb.kind_seen[KIND_BYTE],
                 sb.kind_seen[KIND_HALF], sb.kind_seen[KIND_WORD]);
        if (sb.errors == 0 && apb_faults == 0 && sb.due.size() == 0)
            $display("colorkey_sprite_store_emitter verification clean");
        else
            $display("colorkey_sprite_store_emitter verification failed");
        $finish;
    end

endmodule
